// ===== sv/spk128_pkg.sv =====
`default_nettype none

package spk128_pkg;

  // Word width of the cipher and the rotation amounts of the round function.
  localparam int unsigned WordW = 64;
  localparam int unsigned RotX  = 8;
  localparam int unsigned RotY  = 3;

  // Configuration port geometry: 64-bit registers at byte addresses 8*i.
  localparam int unsigned CfgDataW = 64;
  localparam int unsigned CfgAddrW = 4;
  localparam int unsigned CfgSelBit = 3;

  // Register select codes, taken from the address bit above the word offset.
  localparam logic REG_KEY_K = 1'b0;
  localparam logic REG_KEY_L = 1'b1;

  typedef logic [WordW-1:0] word_t;

  // Everything one round needs: the data words and the key schedule words.
  typedef struct packed {
    word_t y;
    word_t x;
    word_t k;
    word_t l;
  } spk_state_t;

endpackage

`default_nettype wire

// ===== sv/spk128_round.sv =====
`default_nettype none

module spk128_round #(
  parameter int unsigned ROUND_IDX = 0
) (
  input  wire                          clk_i,
  input  wire                          load_i,
  input  wire spk128_pkg::spk_state_t  state_i,
  output spk128_pkg::spk_state_t       state_o
);

  localparam int unsigned W = spk128_pkg::WordW;

  spk128_pkg::word_t     x_ror;
  spk128_pkg::word_t     y_rol;
  spk128_pkg::word_t     l_ror;
  spk128_pkg::word_t     k_rol;
  spk128_pkg::word_t     x_new;
  spk128_pkg::word_t     l_new;
  spk128_pkg::spk_state_t state_d;
  spk128_pkg::spk_state_t state_q;

  // Fixed rotations are plain wiring.
  assign x_ror = {state_i.x[spk128_pkg::RotX-1:0], state_i.x[W-1:spk128_pkg::RotX]};
  assign y_rol = {state_i.y[W-spk128_pkg::RotY-1:0], state_i.y[W-1:W-spk128_pkg::RotY]};
  assign l_ror = {state_i.l[spk128_pkg::RotX-1:0], state_i.l[W-1:spk128_pkg::RotX]};
  assign k_rol = {state_i.k[W-spk128_pkg::RotY-1:0], state_i.k[W-1:W-spk128_pkg::RotY]};

  // Data round uses the round key from before this round's schedule update.
  assign x_new = (x_ror + state_i.y) ^ state_i.k;
  assign l_new = (l_ror + state_i.k) ^ W'(ROUND_IDX);

  always_comb begin
    state_d.x = x_new;
    state_d.y = y_rol ^ x_new;
    state_d.l = l_new;
    state_d.k = k_rol ^ l_new;
  end

  // Payload register; the valid bit lives with the pipeline control.
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      state_q <= state_d;
    end
  end

  assign state_o = state_q;

endmodule

`default_nettype wire

// ===== sv/speck128_block_encrypt_unit.sv =====
// Speck128/128 block encryption, one round per pipeline stage. Each item is a
// 128-bit plaintext block (plain_y_i, plain_x_i); the result item is the
// ciphertext after ROUND_COUNT rounds. The key words k and l are 64-bit
// registers on the APB port at byte addresses 0 and 8 (address bit 3 selects
// the register, the low three bits are ignored); write them only while the
// pipeline is empty. The pipeline takes one item per cycle while the output
// is not stalled; each item passes through the round stages in order, the last
// stage being the output register. A stall on the output lets items close up
// behind it, so bubbles are squeezed out before the input is stalled.
`default_nettype none

module speck128_block_encrypt_unit #(
  parameter int unsigned ROUND_COUNT = 32
) (
  input  wire                                    clk_i,
  input  wire                                    rst_ni,
  // configuration port
  input  wire                                    psel,
  input  wire                                    penable,
  input  wire                                    pwrite,
  input  wire  [spk128_pkg::CfgAddrW-1:0]        paddr,
  input  wire  [spk128_pkg::CfgDataW-1:0]        pwdata,
  output logic [spk128_pkg::CfgDataW-1:0]        prdata,
  output logic                                   pready,
  // input channel
  input  wire                                    in_valid_i,
  output logic                                   in_stall_o,
  input  wire  [spk128_pkg::WordW-1:0]           plain_y_i,
  input  wire  [spk128_pkg::WordW-1:0]           plain_x_i,
  // output channel
  output logic                                   out_valid_o,
  input  wire                                    out_stall_i,
  output logic [spk128_pkg::WordW-1:0]           cipher_y_o,
  output logic [spk128_pkg::WordW-1:0]           cipher_x_o
);

  spk128_pkg::word_t      key_k_q;
  spk128_pkg::word_t      key_l_q;
  logic                   cfg_wr;
  logic                   cfg_sel;

  spk128_pkg::spk_state_t stage_in [ROUND_COUNT];
  spk128_pkg::spk_state_t stage_q  [ROUND_COUNT];
  logic [ROUND_COUNT-1:0] valid_q;
  logic [ROUND_COUNT-1:0] valid_d;
  logic [ROUND_COUNT-1:0] load;

  // APB access: no wait states.
  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_sel = paddr[spk128_pkg::CfgSelBit];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_k_q <= '0;
      key_l_q <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_sel)
        spk128_pkg::REG_KEY_K: key_k_q <= pwdata;
        spk128_pkg::REG_KEY_L: key_l_q <= pwdata;
        default: ;
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    unique case (cfg_sel)
      spk128_pkg::REG_KEY_K: prdata = key_k_q;
      spk128_pkg::REG_KEY_L: prdata = key_l_q;
      default:               prdata = '0;
    endcase
  end

  // A stage loads when it is empty or when its contents move on this cycle.
  always_comb begin
    for (int r = ROUND_COUNT - 1; r >= 0; r--) begin
      if (r == ROUND_COUNT - 1) begin
        load[r] = ~valid_q[r] | ~out_stall_i;
      end else begin
        load[r] = ~valid_q[r] | load[r+1];
      end
    end
  end

  // Valid bits travel with the data.
  always_comb begin
    for (int r = 0; r < ROUND_COUNT; r++) begin
      if (!load[r]) begin
        valid_d[r] = valid_q[r];
      end else if (r == 0) begin
        valid_d[r] = in_valid_i;
      end else begin
        valid_d[r] = valid_q[r-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // The first round takes the plaintext and the current key words.
  assign stage_in[0] = {plain_y_i, plain_x_i, key_k_q, key_l_q};

  for (genvar r = 0; r < ROUND_COUNT; r++) begin : g_round
    if (r > 0) begin : g_link
      assign stage_in[r] = stage_q[r-1];
    end
    spk128_round #(
      .ROUND_IDX (r)
    ) u_round (
      .clk_i   (clk_i),
      .load_i  (load[r]),
      .state_i (stage_in[r]),
      .state_o (stage_q[r])
    );
  end

  assign in_stall_o  = ~load[0];
  assign out_valid_o = valid_q[ROUND_COUNT-1];
  assign cipher_y_o  = stage_q[ROUND_COUNT-1].y;
  assign cipher_x_o  = stage_q[ROUND_COUNT-1].x;

endmodule

`default_nettype wire
